[rtl/cbz_pkg.sv]
// ----------------------------------------------------------------------------
// cbz_pkg
// Shared constants and register codes for the cubic Bezier evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cbz_pkg;

  localparam int T_FRAC_BITS_DEF = 16;
  localparam int COORD_BITS_DEF  = 24;

  // width of the squared distance field and of the per-axis magnitude that is squared
  localparam int DIST_BITS = 52;
  localparam int SQ_BITS   = 26;

  localparam int NUM_REGS     = 8;
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_CTRL0_X = 3'd2,
    REG_CTRL0_Y = 3'd3,
    REG_CTRL1_X = 3'd4,
    REG_CTRL1_Y = 3'd5,
    REG_END_X   = 3'd6,
    REG_END_Y   = 3'd7
  } cfg_reg_t;

endpackage

`default_nettype wire

[rtl/cubic_bezier_evaluator_top.sv]
// ----------------------------------------------------------------------------
// cubic_bezier_evaluator_top
// 2-D cubic Bezier point, first and second derivative and squared distance
// to a query point, seven register stages, one beat per cycle while out_stall is low.
// ----------------------------------------------------------------------------
// throughput: one beat per cycle while out_stall is low, set by the seven-stage multiply pipeline
// stages run on their own enables, so bubbles are squeezed out under out_stall
// reset clears all stage valid bits and sets the eight control point registers
// to zero; point differences used by the derivatives are registered and change in the cycle after a write
`default_nettype none

module cubic_bezier_evaluator_top #(
  parameter int T_FRAC_BITS = cbz_pkg::T_FRAC_BITS_DEF,
  parameter int COORD_BITS  = cbz_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [T_FRAC_BITS:0]                in_param_t,
  input  logic signed [COORD_BITS-1:0]        in_query_x,
  input  logic signed [COORD_BITS-1:0]        in_query_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [COORD_BITS-1:0]        out_point_x,
  output logic signed [COORD_BITS-1:0]        out_point_y,
  output logic signed [COORD_BITS+3:0]        out_slope_x,
  output logic signed [COORD_BITS+3:0]        out_slope_y,
  output logic signed [COORD_BITS+5:0]        out_curvature_x,
  output logic signed [COORD_BITS+5:0]        out_curvature_y,
  output logic [cbz_pkg::DIST_BITS-1:0]       out_distance_squared,
  input  logic                                cfg_wr_en,
  input  logic [cbz_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_data
);

  localparam int F    = T_FRAC_BITS;
  localparam int TW   = F + 1;
  localparam int WW   = TW + 2;
  localparam int CW   = COORD_BITS;
  localparam int SW   = CW + 4;
  localparam int KW   = CW + 6;
  localparam int DW   = CW + 1;
  localparam int EW   = CW + 2;
  localparam int PW   = WW + 1 + CW;
  localparam int PSW  = PW + 3;
  localparam int SPW  = TW + 1 + DW;
  localparam int SSW  = SPW + 6;
  localparam int CPW  = TW + 1 + EW;
  localparam int CSW  = CPW + 5;
  localparam int XW   = cbz_pkg::DIST_BITS;
  localparam int SQW  = cbz_pkg::SQ_BITS;
  localparam int NSTG = 7;

  localparam logic [TW-1:0]          ONE    = TW'(64'd1 << F);
  localparam logic [2*TW-1:0]        UHALF  = (2*TW)'(64'd1 << (F-1));
  localparam logic signed [PSW-1:0]  PHALF  = PSW'(64'd1 << (F-1));
  localparam logic signed [SSW-1:0]  SHALF  = SSW'(64'd1 << (F-1));
  localparam logic signed [CSW-1:0]  CHALF  = CSW'(64'd1 << (F-1));
  localparam logic [63:0]            SQ_LIM = 64'd1 << SQW;

  // rounded Q.F product of two unsigned Q.F values, at most 1.0 when both are
  function automatic logic [TW-1:0] umr(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [2*TW-1:0] p;
    p = a * b;
    p = p + UHALF;
    return p[F+TW-1:F];
  endfunction

  // ---------------- configuration ----------------
  logic signed [CW-1:0] a_r  [2];
  logic signed [CW-1:0] c0_r [2];
  logic signed [CW-1:0] c1_r [2];
  logic signed [CW-1:0] b_r  [2];
  logic signed [DW-1:0] d0_r [2];
  logic signed [DW-1:0] d1_r [2];
  logic signed [DW-1:0] d2_r [2];
  logic signed [EW-1:0] e1_r [2];
  logic signed [EW-1:0] e2_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 2; k++) begin
        a_r[k]  <= '0;
        c0_r[k] <= '0;
        c1_r[k] <= '0;
        b_r[k]  <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cbz_pkg::cfg_reg_t'(cfg_index))
        cbz_pkg::REG_START_X: a_r[0]  <= cfg_data;
        cbz_pkg::REG_START_Y: a_r[1]  <= cfg_data;
        cbz_pkg::REG_CTRL0_X: c0_r[0] <= cfg_data;
        cbz_pkg::REG_CTRL0_Y: c0_r[1] <= cfg_data;
        cbz_pkg::REG_CTRL1_X: c1_r[0] <= cfg_data;
        cbz_pkg::REG_CTRL1_Y: c1_r[1] <= cfg_data;
        cbz_pkg::REG_END_X:   b_r[0]  <= cfg_data;
        cbz_pkg::REG_END_Y:   b_r[1]  <= cfg_data;
      endcase
    end
  end

  // control polygon differences for the derivatives
  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      d0_r[k] <= c0_r[k] - a_r[k];
      d1_r[k] <= c1_r[k] - c0_r[k];
      d2_r[k] <= b_r[k] - c1_r[k];
      e1_r[k] <= c1_r[k] - (c0_r[k] <<< 1) + a_r[k];
      e2_r[k] <= b_r[k] - (c1_r[k] <<< 1) + c0_r[k];
    end
  end

  // ---------------- stage control ----------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] load;

  always_comb begin
    load[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int i = NSTG-2; i >= 0; i--) begin
      load[i] = !vld_r[i] || load[i+1];
    end
    vld_nxt = {vld_r[NSTG-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (load[i]) begin
          vld_r[i] <= vld_nxt[i];
        end
      end
    end
  end

  assign in_stall  = !load[0];
  assign out_valid = vld_r[NSTG-1];

  // ---------------- stage 1: clamp t ----------------
  logic [TW-1:0]        t1_r, u1_r, t1_nxt;
  logic signed [CW-1:0] q1_r [2];

  assign t1_nxt = (in_param_t > ONE) ? ONE : in_param_t;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      t1_r    <= t1_nxt;
      u1_r    <= ONE - t1_nxt;
      q1_r[0] <= in_query_x;
      q1_r[1] <= in_query_y;
    end
  end

  // ---------------- stage 2: quadratic terms ----------------
  logic [TW-1:0]        t2_r, u2_r, uu2_r, ut2_r, tt2_r;
  logic signed [CW-1:0] q2_r [2];

  always_ff @(posedge clk) begin
    if (load[1]) begin
      t2_r  <= t1_r;
      u2_r  <= u1_r;
      uu2_r <= umr(u1_r, u1_r);
      ut2_r <= umr(u1_r, t1_r);
      tt2_r <= umr(t1_r, t1_r);
      q2_r  <= q1_r;
    end
  end

  // ---------------- stage 3: cubic weights, curvature terms ----------------
  logic [TW-1:0]         uu3_r, ut3_r, tt3_r;
  logic [WW-1:0]         w3_r [4];
  logic [WW-1:0]         w_nxt [4];
  logic [TW-1:0]         r1_nxt, r2_nxt;
  logic signed [CPW-1:0] cu3_r [2];
  logic signed [CPW-1:0] ct3_r [2];
  logic signed [CPW-1:0] cu_nxt [2];
  logic signed [CPW-1:0] ct_nxt [2];
  logic signed [CW-1:0]  q3_r [2];

  always_comb begin
    r1_nxt   = umr(uu2_r, t2_r);
    r2_nxt   = umr(tt2_r, u2_r);
    w_nxt[0] = WW'(umr(uu2_r, u2_r));
    w_nxt[1] = WW'(r1_nxt) + (WW'(r1_nxt) << 1);
    w_nxt[2] = WW'(r2_nxt) + (WW'(r2_nxt) << 1);
    w_nxt[3] = WW'(umr(tt2_r, t2_r));
    for (int k = 0; k < 2; k++) begin
      cu_nxt[k] = $signed({1'b0, u2_r}) * e1_r[k];
      ct_nxt[k] = $signed({1'b0, t2_r}) * e2_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      uu3_r <= uu2_r;
      ut3_r <= ut2_r;
      tt3_r <= tt2_r;
      w3_r  <= w_nxt;
      cu3_r <= cu_nxt;
      ct3_r <= ct_nxt;
      q3_r  <= q2_r;
    end
  end

  // ---------------- stage 4: products, curvature result ----------------
  logic signed [PW-1:0]  pp4_r  [2][4];
  logic signed [PW-1:0]  pp_nxt [2][4];
  logic signed [SPW-1:0] sp4_r  [2][3];
  logic signed [SPW-1:0] sp_nxt [2][3];
  logic signed [CSW-1:0] cs_nxt [2];
  logic signed [CSW-1:0] cr_nxt [2];
  logic signed [KW-1:0]  cv_nxt [2];
  logic signed [KW-1:0]  cv4_r  [2];
  logic signed [CW-1:0]  q4_r   [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      pp_nxt[k][0] = $signed({1'b0, w3_r[0]}) * a_r[k];
      pp_nxt[k][1] = $signed({1'b0, w3_r[1]}) * c0_r[k];
      pp_nxt[k][2] = $signed({1'b0, w3_r[2]}) * c1_r[k];
      pp_nxt[k][3] = $signed({1'b0, w3_r[3]}) * b_r[k];
      sp_nxt[k][0] = $signed({1'b0, uu3_r}) * d0_r[k];
      sp_nxt[k][1] = $signed({1'b0, ut3_r}) * d1_r[k];
      sp_nxt[k][2] = $signed({1'b0, tt3_r}) * d2_r[k];
      cs_nxt[k]    = cu3_r[k] + ct3_r[k];
      // times six, round half up
      cr_nxt[k]    = ((cs_nxt[k] <<< 2) + (cs_nxt[k] <<< 1) + CHALF) >>> F;
      if ((&cr_nxt[k][CSW-1:KW-1]) || !(|cr_nxt[k][CSW-1:KW-1])) begin
        cv_nxt[k] = cr_nxt[k][KW-1:0];
      end else begin
        cv_nxt[k] = cr_nxt[k][CSW-1] ? {1'b1, {(KW-1){1'b0}}} : {1'b0, {(KW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      pp4_r <= pp_nxt;
      sp4_r <= sp_nxt;
      cv4_r <= cv_nxt;
      q4_r  <= q3_r;
    end
  end

  // ---------------- stage 5: point and slope sums ----------------
  logic signed [PSW-1:0] ps_nxt [2];
  logic signed [PSW-1:0] pr_nxt [2];
  logic signed [SSW-1:0] ss_nxt [2];
  logic signed [SSW-1:0] sr_nxt [2];
  logic signed [CW-1:0]  pt_nxt [2];
  logic signed [SW-1:0]  sl_nxt [2];
  logic signed [CW-1:0]  pt5_r  [2];
  logic signed [SW-1:0]  sl5_r  [2];
  logic signed [KW-1:0]  cv5_r  [2];
  logic signed [CW-1:0]  q5_r   [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      ps_nxt[k] = pp4_r[k][0] + pp4_r[k][1] + pp4_r[k][2] + pp4_r[k][3];
      pr_nxt[k] = (ps_nxt[k] + PHALF) >>> F;
      if ((&pr_nxt[k][PSW-1:CW-1]) || !(|pr_nxt[k][PSW-1:CW-1])) begin
        pt_nxt[k] = pr_nxt[k][CW-1:0];
      end else begin
        pt_nxt[k] = pr_nxt[k][PSW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end

      // 3 uu d0 + 6 ut d1 + 3 tt d2
      ss_nxt[k] = (sp4_r[k][0] <<< 1) + sp4_r[k][0]
                + (sp4_r[k][1] <<< 2) + (sp4_r[k][1] <<< 1)
                + (sp4_r[k][2] <<< 1) + sp4_r[k][2];
      sr_nxt[k] = (ss_nxt[k] + SHALF) >>> F;
      if ((&sr_nxt[k][SSW-1:SW-1]) || !(|sr_nxt[k][SSW-1:SW-1])) begin
        sl_nxt[k] = sr_nxt[k][SW-1:0];
      end else begin
        sl_nxt[k] = sr_nxt[k][SSW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[4]) begin
      pt5_r <= pt_nxt;
      sl5_r <= sl_nxt;
      cv5_r <= cv4_r;
      q5_r  <= q4_r;
    end
  end

  // ---------------- stage 6: per-axis squares ----------------
  logic signed [DW-1:0] dif_nxt [2];
  logic [DW-1:0]        mag_nxt [2];
  logic [SQW-1:0]       mlo_nxt [2];
  logic [XW-1:0]        sq6_r   [2];
  logic [1:0]           ovf6_r;
  logic signed [CW-1:0] pt6_r   [2];
  logic signed [SW-1:0] sl6_r   [2];
  logic signed [KW-1:0] cv6_r   [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      dif_nxt[k] = pt5_r[k] - q5_r[k];
      mag_nxt[k] = dif_nxt[k][DW-1] ? DW'(-dif_nxt[k]) : DW'(dif_nxt[k]);
      mlo_nxt[k] = SQW'(mag_nxt[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (load[5]) begin
      for (int k = 0; k < 2; k++) begin
        sq6_r[k]  <= mlo_nxt[k] * mlo_nxt[k];
        ovf6_r[k] <= 64'(mag_nxt[k]) >= SQ_LIM;
      end
      pt6_r <= pt5_r;
      sl6_r <= sl5_r;
      cv6_r <= cv5_r;
    end
  end

  // ---------------- stage 7: distance sum, output register ----------------
  logic [XW:0]   dsum_nxt;
  logic [XW-1:0] dist_nxt;

  always_comb begin
    dsum_nxt = {1'b0, sq6_r[0]} + {1'b0, sq6_r[1]};
    if ((|ovf6_r) || dsum_nxt[XW]) begin
      dist_nxt = {XW{1'b1}};
    end else begin
      dist_nxt = dsum_nxt[XW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load[6]) begin
      out_point_x          <= pt6_r[0];
      out_point_y          <= pt6_r[1];
      out_slope_x          <= sl6_r[0];
      out_slope_y          <= sl6_r[1];
      out_curvature_x      <= cv6_r[0];
      out_curvature_y      <= cv6_r[1];
      out_distance_squared <= dist_nxt;
    end
  end

  // ---------------- assertions ----------------
  a_empty_out_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output stage is empty");

  a_clamped_t: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> (t1_r <= ONE) && (TW'(t1_r + u1_r) == ONE))
    else $error("clamped t and 1-t do not sum to one");

  a_weights_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> (uu3_r <= ONE) && (ut3_r <= ONE) && (tt3_r <= ONE))
    else $error("quadratic term above one");

  a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NSTG-2] && load[NSTG-1]) |=> out_valid)
    else $error("beat lost between last stages");

endmodule

`default_nettype wire
